// ===== rtl/lbd_pkg.sv =====
`default_nettype none
package lbd_pkg;

	localparam int MAX_SERVERS = 8;
	localparam int SPACE_BITS  = 16;
	localparam int WEIGHT_BITS = 8;

	localparam int IDX_W       = $clog2(MAX_SERVERS);
	localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
	localparam int REM_W       = IDX_W + 1;

	localparam int ID_W        = 4;
	localparam int FREE_W      = 16;
	localparam int TARGET_W    = 3;
	localparam int SCOUNT_W    = 4;
	localparam int WEIGHTS_W   = 64;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 64;

	localparam int LFSR_W      = 32;
	localparam int DIGIT_W     = 8;
	localparam int DIV_STEPS   = LFSR_W / DIGIT_W;
	localparam int STEP_W      = $clog2(DIV_STEPS);
	localparam logic [LFSR_W-1:0] LFSR_MASK = 32'h8020_0003;

	localparam logic CMD_STATUS    = 1'b0;
	localparam logic CMD_REQUEST   = 1'b1;
	localparam logic KIND_DISPATCH = 1'b0;
	localparam logic KIND_DONE     = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MODE    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCOUNT  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEED    = 4'd3;

	localparam logic [SCOUNT_W-1:0]  SCOUNT_RESET  = 4'd8;
	localparam logic [WEIGHTS_W-1:0] WEIGHTS_RESET = 64'h0101_0101_0101_0101;
	localparam logic [LFSR_W-1:0]    SEED_RESET    = 32'd1;

	typedef enum logic [1:0] {
		MODE_RANDOM = 2'd0,
		MODE_RR     = 2'd1,
		MODE_WRR    = 2'd2,
		MODE_LEAST  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                mode;
		logic [CNT_W-1:0]     n;
		logic [WEIGHTS_W-1:0] weights;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] n;
	} rand_ctl_t;

	typedef struct packed {
		logic             done;
		logic [IDX_W-1:0] pick;
	} rand_sts_t;

	typedef struct packed {
		logic             valid;
		logic             kind;
		logic [IDX_W-1:0] target;
	} res_t;

	// zero weight and weights past the packed word both count as one
	function automatic logic [WEIGHT_BITS-1:0] weight_of(input logic [WEIGHTS_W-1:0] w,
			input logic [IDX_W-1:0] i);
		logic [WEIGHTS_W-1:0]   sh;
		logic [WEIGHT_BITS-1:0] v;
		sh = w >> (int'(i) * WEIGHT_BITS);
		v  = sh[WEIGHT_BITS-1:0];
		if ((int'(i) + 1) * WEIGHT_BITS > WEIGHTS_W || v == '0) begin
			v = WEIGHT_BITS'(1);
		end
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/lbd_rand.sv =====
`default_nettype none
module lbd_rand import lbd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              seed_load,
	input  wire logic [LFSR_W-1:0] seed,
	input  wire rand_ctl_t         ctl,
	output rand_sts_t              sts
);

	logic [LFSR_W-1:0] lfsr_q;
	logic [LFSR_W-1:0] word_q;
	logic [IDX_W-1:0]  rem_q;
	logic [CNT_W-1:0]  n_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [LFSR_W-1:0] lfsr_nxt;
	logic [IDX_W-1:0]  rem_nxt;

	always_comb begin
		lfsr_nxt = {1'b0, lfsr_q[LFSR_W-1:1]};
		if (lfsr_q[0]) begin
			lfsr_nxt = lfsr_nxt ^ LFSR_MASK;
		end
	end

	// restoring remainder, one digit of the word per cycle while no seed load holds it
	always_comb begin
		logic [IDX_W-1:0] r;
		logic [REM_W-1:0] p;
		r = rem_q;
		for (int k = 0; k < DIGIT_W; k++) begin
			p = {r, word_q[LFSR_W-1-k]};
			if (p >= REM_W'(n_q)) begin
				p = p - REM_W'(n_q);
			end
			r = p[IDX_W-1:0];
		end
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= SEED_RESET;
			word_q <= '0;
			rem_q  <= '0;
			n_q    <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (seed_load) begin
				lfsr_q <= (seed == '0) ? LFSR_W'(1) : seed;
			end else if (ctl.start) begin
				lfsr_q <= lfsr_nxt;
				word_q <= lfsr_nxt;
				rem_q  <= '0;
				n_q    <= ctl.n;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= rem_nxt;
				word_q <= word_q << DIGIT_W;
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.done = done_q;
	assign sts.pick = rem_q;

endmodule
`default_nettype wire

// ===== rtl/lbd_seq.sv =====
`default_nettype none
module lbd_seq import lbd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              command,
	input  wire logic [ID_W-1:0]   server_id,
	input  wire logic [FREE_W-1:0] free_space,
	input  wire cfg_t              cfg,
	output rand_ctl_t              rand_ctl,
	input  wire rand_sts_t         rand_sts,
	output res_t                   emit,
	input  wire logic              emit_ready
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_WRR  = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_RAND = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q;

	logic [SPACE_BITS-1:0]  sp_mem [MAX_SERVERS];
	logic [WEIGHT_BITS-1:0] cnt_mem [MAX_SERVERS];
	logic [MAX_SERVERS-1:0] sp_vld_q;
	logic [MAX_SERVERS-1:0] cnt_vld_q;

	logic [SPACE_BITS-1:0]  sp_rdata_s1;
	logic                   sp_rvld_s1;
	logic [IDX_W-1:0]       sp_ridx_s1;
	logic [WEIGHT_BITS-1:0] cnt_rdata_s1;
	logic                   cnt_rvld_s1;

	logic [IDX_W-1:0]      rr_q;
	logic [IDX_W-1:0]      wrr_q;
	logic [CNT_W-1:0]      reports_q;
	logic                  configured_q;
	logic [CNT_W-1:0]      scan_addr_q;
	logic [SPACE_BITS-1:0] best_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic                  res_kind_q;
	logic [IDX_W-1:0]      res_target_q;

	logic                   take;
	logic                   is_req;
	logic                   id_ok;
	logic [CNT_W:0]         rep_inc;
	logic [IDX_W-1:0]       rr_t;
	logic [CNT_W-1:0]       rr_inc;
	logic [IDX_W-1:0]       rr_nxt;
	logic [IDX_W-1:0]       wrr_t;
	logic [CNT_W-1:0]       wrr_inc;
	logic [IDX_W-1:0]       wrr_nxt;
	logic                   sp_we;
	logic [IDX_W-1:0]       sp_waddr;
	logic                   sp_re;
	logic [IDX_W-1:0]       sp_raddr;
	logic                   cnt_re;
	logic                   cnt_we;
	logic [WEIGHT_BITS-1:0] cnt_wdata;
	logic [SPACE_BITS-1:0]  sp_rd;
	logic [WEIGHT_BITS-1:0] cnt_rd;
	logic [WEIGHT_BITS:0]   cnt_inc;
	logic                   wrap;
	logic [SPACE_BITS-1:0]  cand_best;
	logic [IDX_W-1:0]       cand_idx;
	logic                   scan_last;

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;
	assign is_req   = (command == CMD_REQUEST);
	assign id_ok    = (server_id != '0) && (server_id <= cfg.n);
	assign rep_inc  = {1'b0, reports_q} + (CNT_W + 1)'(1);

	// pointers left beyond a lowered count restart at zero
	assign rr_t    = (rr_q >= cfg.n) ? '0 : rr_q;
	assign rr_inc  = CNT_W'(rr_t) + CNT_W'(1);
	assign rr_nxt  = (rr_inc >= cfg.n) ? '0 : IDX_W'(rr_inc);
	assign wrr_t   = (wrr_q >= cfg.n) ? '0 : wrr_q;
	assign wrr_inc = CNT_W'(wrr_q) + CNT_W'(1);
	assign wrr_nxt = (wrr_inc >= cfg.n) ? '0 : IDX_W'(wrr_inc);

	// entries never written read as zero
	assign sp_rd   = sp_rvld_s1 ? sp_rdata_s1 : '0;
	assign cnt_rd  = cnt_rvld_s1 ? cnt_rdata_s1 : '0;
	assign cnt_inc = {1'b0, cnt_rd} + (WEIGHT_BITS + 1)'(1);
	assign wrap    = (cnt_inc >= {1'b0, weight_of(cfg.weights, wrr_q)});
	assign cnt_wdata = wrap ? '0 : cnt_inc[WEIGHT_BITS-1:0];

	assign sp_we    = take && !is_req && id_ok;
	assign sp_waddr = IDX_W'(server_id - ID_W'(1));
	assign cnt_re   = take && is_req && (cfg.mode == MODE_WRR);
	assign cnt_we   = (state_q == ST_WRR);

	always_comb begin
		sp_re    = 1'b0;
		sp_raddr = '0;
		if (take && is_req && cfg.mode == MODE_LEAST) begin
			sp_re = 1'b1;
		end else if (state_q == ST_SCAN && scan_addr_q < cfg.n) begin
			sp_re    = 1'b1;
			sp_raddr = scan_addr_q[IDX_W-1:0];
		end
	end

	// first strict maximum; entry zero seeds the running best
	always_comb begin
		cand_best = best_q;
		cand_idx  = best_idx_q;
		if (sp_ridx_s1 == '0) begin
			cand_best = sp_rd;
			cand_idx  = '0;
		end else if (sp_rd > best_q) begin
			cand_best = sp_rd;
			cand_idx  = sp_ridx_s1;
		end
	end

	assign scan_last = (state_q == ST_SCAN) && (CNT_W'(sp_ridx_s1) + CNT_W'(1) == cfg.n);

	assign rand_ctl.start = (take && is_req && cfg.mode == MODE_RANDOM) ||
		(scan_last && cand_idx == '0);
	assign rand_ctl.n     = cfg.n;

	always_ff @(posedge clk) begin
		if (sp_we) begin
			sp_mem[sp_waddr] <= SPACE_BITS'(free_space);
		end
		if (sp_re) begin
			sp_rdata_s1 <= sp_mem[sp_raddr];
			sp_rvld_s1  <= sp_vld_q[sp_raddr];
			sp_ridx_s1  <= sp_raddr;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[wrr_q] <= cnt_wdata;
		end
		if (cnt_re) begin
			cnt_rdata_s1 <= cnt_mem[wrr_t];
			cnt_rvld_s1  <= cnt_vld_q[wrr_t];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			sp_vld_q     <= '0;
			cnt_vld_q    <= '0;
			rr_q         <= '0;
			wrr_q        <= '0;
			reports_q    <= '0;
			configured_q <= 1'b0;
			scan_addr_q  <= '0;
			best_q       <= '0;
			best_idx_q   <= '0;
			res_kind_q   <= KIND_DISPATCH;
			res_target_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take && !is_req) begin
						if (id_ok) begin
							sp_vld_q[sp_waddr] <= 1'b1;
							if (!configured_q) begin
								reports_q <= rep_inc[CNT_W-1:0];
								if (rep_inc >= (CNT_W + 1)'(cfg.n)) begin
									configured_q <= 1'b1;
									res_kind_q   <= KIND_DONE;
									res_target_q <= '0;
									state_q      <= ST_EMIT;
								end
							end
						end
					end else if (take) begin
						case (cfg.mode)
							MODE_RANDOM: begin
								state_q <= ST_RAND;
							end
							MODE_RR: begin
								rr_q         <= rr_nxt;
								res_kind_q   <= KIND_DISPATCH;
								res_target_q <= rr_t;
								state_q      <= ST_EMIT;
							end
							MODE_WRR: begin
								wrr_q   <= wrr_t;
								state_q <= ST_WRR;
							end
							default: begin
								scan_addr_q <= CNT_W'(1);
								state_q     <= ST_SCAN;
							end
						endcase
					end
				end
				ST_WRR: begin
					cnt_vld_q[wrr_q] <= 1'b1;
					if (wrap) begin
						wrr_q <= wrr_nxt;
					end
					res_kind_q   <= KIND_DISPATCH;
					res_target_q <= wrr_q;
					state_q      <= ST_EMIT;
				end
				ST_SCAN: begin
					best_q     <= cand_best;
					best_idx_q <= cand_idx;
					if (sp_re) begin
						scan_addr_q <= scan_addr_q + CNT_W'(1);
					end
					if (scan_last) begin
						if (cand_idx == '0) begin
							state_q <= ST_RAND;
						end else begin
							res_kind_q   <= KIND_DISPATCH;
							res_target_q <= cand_idx;
							state_q      <= ST_EMIT;
						end
					end
				end
				ST_RAND: begin
					if (rand_sts.done) begin
						res_kind_q   <= KIND_DISPATCH;
						res_target_q <= rand_sts.pick;
						state_q      <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign emit.valid  = (state_q == ST_EMIT);
	assign emit.kind   = res_kind_q;
	assign emit.target = res_target_q;

endmodule
`default_nettype wire

// ===== rtl/load_balancer_dispatch_top.sv =====
`default_nettype none
// Dispatcher that picks a target server per connection request in random, round robin,
// weighted round robin or least connections mode; status updates store a server's free
// space, and the update that completes the server count returns a one-time done result.
// One request is in flight at a time: a status update (through the emit state when it
// completes the count), round robin, weighted round robin (read-modify-write of the repeat
// counter memory), random (LFSR step then a remainder unit that takes 8 bits per cycle)
// and least connections (scan of the free-space memory over the effective server count,
// then the random draw when server 0 holds the maximum) each finish before the next is
// taken. Results sit in an output register, so the next request is taken while a result
// waits. Both memories reset through per-entry valid bits, with no clearing pass. The
// configuration port never stalls.
module load_balancer_dispatch_top import lbd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  command,
	input  wire logic [ID_W-1:0]       server_id,
	input  wire logic [FREE_W-1:0]     free_space,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       result_kind,
	output logic [TARGET_W-1:0]        target,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	mode_t                mode_q;
	logic [SCOUNT_W-1:0]  scount_q;
	logic [WEIGHTS_W-1:0] weights_q;
	logic                 out_valid_q;
	logic                 out_kind_q;
	logic [TARGET_W-1:0]  out_target_q;

	logic       cfg_we;
	logic       seed_load;
	cfg_t       cfg;
	rand_ctl_t  rand_ctl;
	rand_sts_t  rand_sts;
	res_t       emit;
	logic       emit_ready;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign seed_load = cfg_we && (cfg_index == REG_SEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_RR;
			scount_q  <= SCOUNT_RESET;
			weights_q <= WEIGHTS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:    mode_q    <= mode_t'(cfg_data[1:0]);
				REG_SCOUNT:  scount_q  <= cfg_data[SCOUNT_W-1:0];
				REG_WEIGHTS: weights_q <= cfg_data[WEIGHTS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// out-of-range server counts clamp to 1..MAX_SERVERS
	always_comb begin
		cfg.mode    = mode_q;
		cfg.weights = weights_q;
		if (scount_q == '0) begin
			cfg.n = CNT_W'(1);
		end else if (scount_q > SCOUNT_W'(MAX_SERVERS)) begin
			cfg.n = CNT_W'(MAX_SERVERS);
		end else begin
			cfg.n = CNT_W'(scount_q);
		end
	end

	lbd_rand u_rand (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_load (seed_load),
		.seed      (cfg_data[LFSR_W-1:0]),
		.ctl       (rand_ctl),
		.sts       (rand_sts)
	);

	lbd_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.server_id  (server_id),
		.free_space (free_space),
		.cfg        (cfg),
		.rand_ctl   (rand_ctl),
		.rand_sts   (rand_sts),
		.emit       (emit),
		.emit_ready (emit_ready)
	);

	assign emit_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_kind_q   <= KIND_DISPATCH;
			out_target_q <= '0;
		end else if (emit_ready) begin
			out_valid_q <= emit.valid;
			if (emit.valid) begin
				out_kind_q   <= emit.kind;
				out_target_q <= TARGET_W'(emit.target);
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign target      = out_target_q;

endmodule
`default_nettype wire

// ===== rtl/lbd_checker.sv =====
`default_nettype none
module lbd_checker import lbd_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  command,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic                  result_kind,
	input wire logic [TARGET_W-1:0]   target,
	input wire logic                  cfg_valid,
	input wire logic                  cfg_ready
);

	logic done_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_seen_q <= 1'b0;
		end else if (out_valid && out_ready && result_kind == KIND_DONE) begin
			done_seen_q <= 1'b1;
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(target))
		else $error("result changed while stalled");

	// done result carries target zero
	a_done_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_DONE |-> target == '0)
		else $error("done result with nonzero target");

	// done is reported once per reset
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_DONE |-> !done_seen_q)
		else $error("second done result");

	// a request leaves the block busy, so requests are not accepted back to back
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_REQUEST |=> !in_ready)
		else $error("request accepted back to back");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind load_balancer_dispatch_top lbd_checker u_lbd_checker (.*);
`default_nettype wire

// ===== tb/sv/dispatch_checker.sv =====
`timescale 1ns / 1ps
module dispatch_checker import lbd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire logic                  command,
	input  wire logic [ID_W-1:0]       server_id,
	input  wire logic [FREE_W-1:0]     free_space,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire logic                  result_kind,
	input  wire logic [TARGET_W-1:0]   target,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         mismatches,
	output int                         outstanding
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic                kind;
		logic [TARGET_W-1:0] target;
	} decision_t;

	decision_t decision_q[$];
	decision_t head;

	mode_t                  mode_r;
	logic [SCOUNT_W-1:0]    scount_r;
	logic [WEIGHTS_W-1:0]   weights_r;
	logic [LFSR_W-1:0]      lfsr_r;
	logic [SPACE_BITS-1:0]  space_tab [MAX_SERVERS];
	logic [WEIGHT_BITS-1:0] repeat_cnt [MAX_SERVERS];
	int                     rr_ptr;
	int                     wrr_ptr;
	int                     reports;
	logic                   configured;

	function automatic int active_servers();
		if (scount_r == 0) begin
			return 1;
		end
		if (scount_r > MAX_SERVERS) begin
			return MAX_SERVERS;
		end
		return int'(scount_r);
	endfunction

	// galois step, then the new value picks the server
	function automatic int lfsr_draw(input int n);
		logic shifted_out;
		shifted_out = lfsr_r[0];
		lfsr_r = lfsr_r >> 1;
		if (shifted_out) begin
			lfsr_r = lfsr_r ^ LFSR_MASK;
		end
		return int'(lfsr_r % LFSR_W'(n));
	endfunction

	task automatic choose_server(input logic cmd, input logic [ID_W-1:0] id,
			input logic [FREE_W-1:0] space);
		int                     n;
		int                     pick;
		int                     best_i;
		logic [SPACE_BITS-1:0]  best;
		logic [WEIGHT_BITS-1:0] w;
		decision_t              d;
		n = active_servers();
		if (cmd == CMD_STATUS) begin
			if (id == 0 || id > n) begin
				return;
			end
			space_tab[id - 1] = space[SPACE_BITS-1:0];
			if (configured) begin
				return;
			end
			reports++;
			if (reports < n) begin
				return;
			end
			configured = 1'b1;
			d.kind = KIND_DONE;
			d.target = '0;
			decision_q.insert(decision_q.size(), d);
			return;
		end
		case (mode_r)
			MODE_RANDOM: begin
				pick = lfsr_draw(n);
			end
			MODE_RR: begin
				if (rr_ptr >= n) begin
					rr_ptr = 0;
				end
				pick = rr_ptr;
				rr_ptr = (rr_ptr + 1 >= n) ? 0 : rr_ptr + 1;
			end
			MODE_WRR: begin
				if (wrr_ptr >= n) begin
					wrr_ptr = 0;
				end
				pick = wrr_ptr;
				repeat_cnt[pick] = repeat_cnt[pick] + 1'b1;
				w = weights_r[pick*WEIGHT_BITS +: WEIGHT_BITS];
				if (w == 0) begin
					w = WEIGHT_BITS'(1);
				end
				// a lowered weight also ends the current server's run
				if (repeat_cnt[pick] >= w) begin
					repeat_cnt[pick] = '0;
					wrr_ptr = (pick + 1 >= n) ? 0 : pick + 1;
				end
			end
			default: begin
				best = space_tab[0];
				best_i = 0;
				for (int i = 1; i < n; i++) begin
					if (space_tab[i] > best) begin
						best = space_tab[i];
						best_i = i;
					end
				end
				// server 0 on top, ties included, falls back to random
				pick = (best_i == 0) ? lfsr_draw(n) : best_i;
			end
		endcase
		d.kind = KIND_DISPATCH;
		d.target = TARGET_W'(pick);
		decision_q.insert(decision_q.size(), d);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_r = MODE_RR;
			scount_r = SCOUNT_RESET;
			weights_r = WEIGHTS_RESET;
			lfsr_r = SEED_RESET;
			for (int i = 0; i < MAX_SERVERS; i++) begin
				space_tab[i] = '0;
				repeat_cnt[i] = '0;
			end
			rr_ptr = 0;
			wrr_ptr = 0;
			reports = 0;
			configured = 1'b0;
			decision_q.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (decision_q.size() == 0) begin
					if (mismatches < REPORT_LIMIT) begin
						$display("unexpected result at %0t: kind %0d target %0d",
							$realtime, result_kind, target);
					end
					mismatches++;
				end else begin
					head = decision_q.pop_front();
					if (result_kind !== head.kind || target !== head.target) begin
						if (mismatches < REPORT_LIMIT) begin
							$display("mismatch at %0t: kind %0d/%0d target %0d/%0d (exp/got)",
								$realtime, head.kind, result_kind, head.target, target);
						end
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE:    mode_r = mode_t'(cfg_data[1:0]);
					REG_SCOUNT:  scount_r = cfg_data[SCOUNT_W-1:0];
					REG_WEIGHTS: weights_r = cfg_data[WEIGHTS_W-1:0];
					REG_SEED: begin
						lfsr_r = (cfg_data[LFSR_W-1:0] == 0) ? LFSR_W'(1) : cfg_data[LFSR_W-1:0];
					end
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				choose_server(command, server_id, free_space);
			end
			outstanding = decision_q.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import lbd_pkg::*;

	localparam int DRAIN_CYCLES   = 24;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int NUM_SEGMENTS   = 12;
	localparam int SEG_ITEMS      = 58;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  command;
	logic [ID_W-1:0]       server_id;
	logic [FREE_W-1:0]     free_space;
	logic                  out_valid;
	logic                  out_ready;
	logic                  result_kind;
	logic [TARGET_W-1:0]   target;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    outstanding;

	int                    in_idle;
	int                    out_idle;
	int                    quiet_cycles;
	int                    servers;
	int                    scount;
	int                    pick;
	logic [CFG_DATA_W-1:0] word;
	logic [ID_W-1:0]       sid;
	logic [FREE_W-1:0]     fspace;

	load_balancer_dispatch_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.server_id   (server_id),
		.free_space  (free_space),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.target      (target),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	dispatch_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.server_id   (server_id),
		.free_space  (free_space),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.target      (target),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= out_idle);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// one request per call, entered and left at a falling edge
	task automatic issue(input logic cmd, input logic [ID_W-1:0] id,
			input logic [FREE_W-1:0] space);
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < in_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		server_id <= id;
		free_space <= space;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// status updates give no result, so allow the block to finish them too
	task automatic quiesce();
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_STATUS;
		server_id = '0;
		free_space = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		in_idle = 28;
		out_idle = 64;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// round robin from reset, bad ids, repeated report, config done
		issue(CMD_REQUEST, 4'd0, 16'h0000);
		issue(CMD_REQUEST, 4'hF, 16'hFFFF);
		issue(CMD_STATUS, 4'd0, 16'h1111);
		issue(CMD_STATUS, 4'd9, 16'h2222);
		issue(CMD_STATUS, 4'hF, 16'h3333);
		issue(CMD_STATUS, 4'd1, 16'hFFFF);
		issue(CMD_STATUS, 4'd1, 16'h0000);
		for (int id = 2; id <= 7; id++) begin
			issue(CMD_STATUS, ID_W'(id), FREE_W'(id * 16'h1000));
		end
		issue(CMD_STATUS, 4'd8, 16'hFFFF);

		quiesce();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_LEAST));
		issue(CMD_REQUEST, 4'd0, 16'h0000);
		issue(CMD_STATUS, 4'd8, 16'h0000);
		issue(CMD_REQUEST, 4'd0, 16'h0000);
		// server 0 on top falls back to random
		issue(CMD_STATUS, 4'd1, 16'hFFFF);
		issue(CMD_REQUEST, 4'd0, 16'h0000);

		quiesce();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_RANDOM));
		write_reg(REG_SEED, '0);
		issue(CMD_REQUEST, 4'd0, 16'h0000);
		issue(CMD_REQUEST, 4'd0, 16'h0000);

		quiesce();
		write_reg(REG_SCOUNT, CFG_DATA_W'(2));
		write_reg(REG_WEIGHTS, 64'h0000_0000_0000_0300);
		write_reg(REG_MODE, CFG_DATA_W'(MODE_WRR));
		repeat (5) issue(CMD_REQUEST, 4'd0, 16'h0000);

		for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
			quiesce();
			case (seg / 4)
				0: begin
					in_idle = 28;
					out_idle = 64;
				end
				1: begin
					in_idle = 64;
					out_idle = 28;
				end
				default: begin
					in_idle = 0;
					out_idle = 0;
				end
			endcase
			case (seg)
				0, 7, 11: scount = 8;
				1:        scount = 1;
				2:        scount = 3;
				3:        scount = 0;
				4:        scount = 15;
				5:        scount = 5;
				6:        scount = 2;
				8:        scount = 7;
				9:        scount = 4;
				default:  scount = 6;
			endcase
			servers = (scount == 0) ? 1 : (scount > MAX_SERVERS) ? MAX_SERVERS : scount;

			word = {$urandom, $urandom};
			word[1:0] = 2'(seg % 4);
			write_reg(REG_MODE, word);
			word = {$urandom, $urandom};
			word[SCOUNT_W-1:0] = SCOUNT_W'(scount);
			write_reg(REG_SCOUNT, word);
			if (seg == 6) begin
				word = '1;
			end else if (seg % 4 == 2) begin
				for (int b = 0; b < 8; b++) begin
					pick = $urandom_range(9);
					word[b*8 +: 8] = (pick == 0) ? 8'h00 :
						(pick == 9) ? 8'hFF : 8'($urandom_range(1, 5));
				end
			end else begin
				word = {$urandom, $urandom};
			end
			write_reg(REG_WEIGHTS, word);
			word = {$urandom, $urandom};
			if (seg == 0) begin
				word[31:0] = '0;
			end else if (seg == 4) begin
				word[31:0] = '1;
			end
			write_reg(REG_SEED, word);
			if (seg == 1) begin
				write_reg(REG_UNUSED, {$urandom, $urandom});
			end

			for (int k = 0; k < SEG_ITEMS; k++) begin
				pick = $urandom_range(4);
				fspace = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : FREE_W'($urandom);
				if ($urandom_range(99) < 35) begin
					sid = ($urandom_range(9) == 0) ? ID_W'($urandom_range(15)) :
						ID_W'($urandom_range(1, servers));
					issue(CMD_STATUS, sid, fspace);
				end else begin
					issue(CMD_REQUEST, ID_W'($urandom), fspace);
				end
			end
		end

		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
